[rtl/core/websocket_frame_unmask_unit_defines.svh]
// Assertion macros for the checker file of the frame unmask unit.
`ifndef WEBSOCKET_FRAME_UNMASK_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASK_UNIT_DEFINES_SVH

// Checked on every rising edge of clk while rst is low.
`define WSU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define WSU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/wsu_pkg.sv]
// Shared types and constants of the WebSocket frame unmask unit.
package wsu_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 4096;

  localparam int TEXT_W = 13;
  localparam logic [TEXT_W-1:0] TEXT_MAX = '1;

  localparam logic [3:0] OPCODE_CLOSE = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header sizes for the three length encodings, mask key included.
  localparam int HDR_BYTES_SHORT = 6;
  localparam int HDR_BYTES_16 = 8;
  localparam int HDR_BYTES_64 = 14;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES = 4'd4;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_UNMASKED = 2'd2;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd3;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    LEN_KIND_SHORT,
    LEN_KIND_16,
    LEN_KIND_64
  } len_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              byte_valid;
    logic              is_end;
    logic [1:0]        frame_status;
    logic [TEXT_W-1:0] text_length;
  } result_item_t;

  typedef struct packed {
    logic         valid;
    result_item_t item;
  } parse_result_t;

endpackage

[rtl/core/websocket_frame_unmask_unit.sv]
// Top level of the WebSocket frame unmask unit with its output register and skid stage.
//
// The frame channel (frame_valid, frame_stall, frame_item) carries one byte of a
// received buffer per item, with last_byte marking the final byte of the buffer.
// The unit parses one frame header from the start of each buffer, then sends
// every payload byte XORed with the mask key on the result channel (result_valid,
// result_stall, result_item). The item for the last byte also carries is_end,
// the frame status and the count of payload bytes before the first zero byte.
// Header bytes and bytes past the payload produce no result unless they end the
// buffer.
// A result is registered in the output register, or in the skid register when the
// receiver stalls. Throughput is one byte per cycle while the skid register is
// empty; apart from reset, only a full skid register raises frame_stall.
// When the receiver stalls, the pending result holds in the output register and
// one more result lands in the skid register; frame_stall then rises and stays
// high until the receiver takes the item waiting in the output register.
// Reset clears the parser to expect the first header byte, empties both output
// registers and holds frame_stall high; the first byte can be taken once reset
// is low.
module websocket_frame_unmask_unit #(
  parameter int BUFFER_BYTES = wsu_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  output logic                 frame_stall,
  input  wsu_pkg::frame_item_t frame_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output wsu_pkg::result_item_t result_item
);
  import wsu_pkg::*;

  parse_result_t parse_out;
  logic          frame_accept;
  logic          result_fire;
  logic          skid_valid;
  result_item_t  skid_item;

  // Apart from reset, the skid register is the only thing that can push back on
  // the sender, so frame_stall has no path from result_stall.
  assign frame_stall  = rst || skid_valid;
  assign frame_accept = frame_valid && !frame_stall;
  assign result_fire  = result_valid && !result_stall;

  wsu_parse #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (frame_accept),
    .item   (frame_item),
    .result (parse_out)
  );

  // Output register control. A waiting skid item always goes out first; while
  // it waits no new byte is taken, so the parser produces nothing then.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_fire) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (!result_valid || result_fire) begin
      result_valid <= parse_out.valid;
    end else if (parse_out.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload side of the same two registers; no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_fire) begin
        result_item <= skid_item;
      end
    end else if (!result_valid || result_fire) begin
      if (parse_out.valid) begin
        result_item <= parse_out.item;
      end
    end else if (parse_out.valid) begin
      skid_item <= parse_out.item;
    end
  end

endmodule

[rtl/core/wsu_parse.sv]
// Frame header parser, payload unmasking and end-of-buffer status.
module wsu_parse #(
  parameter int BUFFER_BYTES = wsu_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  wsu_pkg::frame_item_t  item,
  output wsu_pkg::parse_result_t result
);
  import wsu_pkg::*;

  localparam int CountW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CountW-1:0] LimitShort = CountW'(BUFFER_BYTES - HDR_BYTES_SHORT);
  localparam logic [CountW-1:0] Limit16 = CountW'(BUFFER_BYTES - HDR_BYTES_16);
  localparam logic [CountW-1:0] Limit64 = CountW'(BUFFER_BYTES - HDR_BYTES_64);

  phase_t            phase, phase_next;
  logic [3:0]        header_index, header_index_next;
  len_kind_t         length_kind, length_kind_next;
  logic [63:0]       declared_length, declared_length_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [CountW-1:0] payload_count, payload_count_next;
  logic [TEXT_W-1:0] text_count, text_count_next;
  logic              zero_seen, zero_seen_next;
  logic [1:0]        reject_code, reject_code_next;

  logic [7:0]        b;
  logic [7:0]        mask_byte;
  logic [7:0]        unmasked;
  logic              emit;
  logic [3:0]        index_inc;
  logic [3:0]        ext_bytes;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] payload_limit;
  logic [1:0]        status;

  assign b = item.data_byte;
  assign index_inc = header_index + 4'd1;
  assign count_inc = payload_count + CountW'(1);
  assign ext_bytes = (length_kind == LEN_KIND_16) ? EXT16_BYTES : EXT64_BYTES;

  always_comb begin
    case (length_kind)
      LEN_KIND_16: payload_limit = Limit16;
      LEN_KIND_64: payload_limit = Limit64;
      default:     payload_limit = LimitShort;
    endcase
  end

  // Payload byte i is masked with key byte i mod 4, first key byte in the top bits.
  always_comb begin
    case (payload_count[1:0])
      2'd0:    mask_byte = mask_key[31:24];
      2'd1:    mask_byte = mask_key[23:16];
      2'd2:    mask_byte = mask_key[15:8];
      default: mask_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    length_kind_next     = length_kind;
    declared_length_next = declared_length;
    mask_key_next        = mask_key;
    payload_count_next   = payload_count;
    text_count_next      = text_count;
    zero_seen_next       = zero_seen;
    reject_code_next     = reject_code;
    unmasked             = '0;
    emit                 = 1'b0;

    case (phase)
      PH_FIRST: begin
        if (!b[7] || b[3:0] == OPCODE_CLOSE || item.last_byte) begin
          reject_code_next = STATUS_REJECT;
          phase_next       = PH_DONE;
        end else begin
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        header_index_next    = '0;
        declared_length_next = '0;
        if (!b[7]) begin
          reject_code_next = STATUS_UNMASKED;
          phase_next       = PH_DONE;
        end else if (b[6:0] == LEN_EXT16) begin
          length_kind_next = LEN_KIND_16;
          phase_next       = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          length_kind_next = LEN_KIND_64;
          phase_next       = PH_EXTLEN;
        end else begin
          length_kind_next     = LEN_KIND_SHORT;
          declared_length_next = 64'(b[6:0]);
          phase_next           = PH_MASK;
        end
      end
      PH_EXTLEN: begin
        declared_length_next = {declared_length[55:0], b};
        if (index_inc >= ext_bytes) begin
          header_index_next = '0;
          phase_next        = PH_MASK;
        end else begin
          header_index_next = index_inc;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], b};
        if (index_inc >= MASK_BYTES) begin
          header_index_next = '0;
          phase_next        = (declared_length == '0) ? PH_DONE : PH_PAYLOAD;
        end else begin
          header_index_next = index_inc;
        end
      end
      PH_PAYLOAD: begin
        unmasked = b ^ mask_byte;
        emit     = 1'b1;
        if (!zero_seen) begin
          if (unmasked == 8'd0) begin
            zero_seen_next = 1'b1;
          end else if (text_count != TEXT_MAX) begin
            text_count_next = text_count + TEXT_W'(1);
          end
        end
        payload_count_next = count_inc;
        if (64'(count_inc) >= declared_length || count_inc >= payload_limit) begin
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (reject_code_next != STATUS_OK) begin
      status = reject_code_next;
    end else if (phase_next == PH_SECOND || phase_next == PH_EXTLEN ||
                 phase_next == PH_MASK) begin
      status = STATUS_INCOMPLETE;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result.valid             = accept && (emit || item.last_byte);
    result.item.payload_byte = unmasked;
    result.item.byte_valid   = emit;
    result.item.is_end       = item.last_byte;
    result.item.frame_status = item.last_byte ? status : STATUS_OK;
    result.item.text_length  = (item.last_byte && status == STATUS_OK) ?
                               text_count_next : '0;
  end

  // The last byte of a buffer returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      phase           <= PH_FIRST;
      header_index    <= '0;
      length_kind     <= LEN_KIND_SHORT;
      declared_length <= '0;
      mask_key        <= '0;
      payload_count   <= '0;
      text_count      <= '0;
      zero_seen       <= 1'b0;
      reject_code     <= STATUS_OK;
    end else if (accept) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      length_kind     <= length_kind_next;
      declared_length <= declared_length_next;
      mask_key        <= mask_key_next;
      payload_count   <= payload_count_next;
      text_count      <= text_count_next;
      zero_seen       <= zero_seen_next;
      reject_code     <= reject_code_next;
    end
  end

endmodule

[rtl/core/wsu_checker.sv]
// Port-level assertions for the WebSocket frame unmask unit and their bind.
`include "websocket_frame_unmask_unit_defines.svh"

module wsu_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  frame_valid,
  input logic                  frame_stall,
  input wsu_pkg::frame_item_t  frame_item,
  input logic                  result_valid,
  input logic                  result_stall,
  input wsu_pkg::result_item_t result_item
);
  import wsu_pkg::*;

  // Every result is either a payload byte or the end of a buffer.
  `WSU_ASSERT(a_result_has_reason, result_valid |-> (result_item.byte_valid || result_item.is_end), "result item is neither payload nor end")

  // Status and text length are only reported on the end item.
  `WSU_ASSERT(a_status_only_at_end, (result_valid && !result_item.is_end) |-> (result_item.frame_status == STATUS_OK && result_item.text_length == '0), "status or length outside end item")

  // A failed frame never carries payload or a text length, and absent payload reads as zero.
  `WSU_ASSERT(a_failed_frame_empty, (result_valid && (result_item.frame_status != STATUS_OK || !result_item.byte_valid)) |-> (result_item.payload_byte == 8'd0 && (result_item.frame_status == STATUS_OK || (!result_item.byte_valid && result_item.text_length == '0))), "failed frame or empty item carries data")

  // A stalled result stays in place.
  `WSU_ASSERT(a_result_holds, (result_valid && result_stall) |=> (result_valid && $stable(result_item)), "stalled result item changed")

  // A stalled input byte stays in place.
  `WSU_ASSERT(a_frame_holds, (frame_valid && frame_stall) |=> (frame_valid && $stable(frame_item)), "stalled frame item changed")

endmodule

bind websocket_frame_unmask_unit wsu_checker u_wsu_checker (.*);
